/* rtl/bbat_pkg.sv */
// ----------------------------------------------------------------------------
// bbat_pkg
// Shared types, widths and constants for the bounding box affine transform.
// ----------------------------------------------------------------------------
package bbat_pkg;

   // Coordinate width of the box corners and the transformed extents (Q8.8).
   localparam int COORD_WIDTH = 16;

   // Layout of one packed matrix row.
   localparam int AXES       = 3;
   localparam int ROW_W      = 64;
   localparam int COEF_W     = 16;
   localparam int COEF_FRAC  = 12;
   localparam int TRANS_W    = 16;
   localparam int TRANS_LSB  = 48;

   // Arithmetic widths along the pipeline.
   localparam int PROD_W     = COEF_W + COORD_WIDTH;
   localparam int TRANS_SH_W = TRANS_W + COEF_FRAC;
   localparam int ACC_W      = ((PROD_W > TRANS_SH_W) ? PROD_W : TRANS_SH_W) + 2;
   localparam int SH_W       = ACC_W - COEF_FRAC;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_ROW_X = csr_index_type'(0);
   localparam csr_index_type CSR_ROW_Y = csr_index_type'(1);
   localparam csr_index_type CSR_ROW_Z = csr_index_type'(2);

   typedef logic [ROW_W-1:0] row_type;

   // Reset rows give the identity matrix with no translation.
   localparam row_type ROW_X_RESET = 64'h0000_0000_0000_1000;
   localparam row_type ROW_Y_RESET = 64'h0000_0000_1000_0000;
   localparam row_type ROW_Z_RESET = 64'h0000_1000_0000_0000;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [COEF_W-1:0]      coef_type;
   typedef logic signed [TRANS_W-1:0]     trans_type;
   typedef logic signed [PROD_W-1:0]      prod_type;
   typedef logic signed [ACC_W-1:0]       acc_type;
   typedef logic signed [SH_W-1:0]        sh_type;

   // Saturation bounds of the output coordinates.
   localparam sh_type SAT_HI = sh_type'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
   localparam sh_type SAT_LO = sh_type'(-(64'sd1 <<< (COORD_WIDTH - 1)));

   typedef struct packed {
      coord_type in_min_x;
      coord_type in_min_y;
      coord_type in_min_z;
      coord_type in_max_x;
      coord_type in_max_y;
      coord_type in_max_z;
   } req_word_type;

   typedef struct packed {
      coord_type out_min_x;
      coord_type out_min_y;
      coord_type out_min_z;
      coord_type out_max_x;
      coord_type out_max_y;
      coord_type out_max_z;
      logic      clipped;
   } rsp_word_type;

endpackage

/* rtl/bbat_mul_stage.sv */
// ----------------------------------------------------------------------------
// bbat_mul_stage
// First stage: multiplies every coefficient by the low and high end of its
// input coordinate, eighteen products in parallel.
// ----------------------------------------------------------------------------
module bbat_mul_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   in_valid,
   input  bbat_pkg::req_word_type req_word,
   input  bbat_pkg::row_type      rows [bbat_pkg::AXES],
   output logic                   out_valid,
   output bbat_pkg::prod_type     lo_prod [bbat_pkg::AXES][bbat_pkg::AXES],
   output bbat_pkg::prod_type     hi_prod [bbat_pkg::AXES][bbat_pkg::AXES]
);

   bbat_pkg::coord_type lo_coord [bbat_pkg::AXES];
   bbat_pkg::coord_type hi_coord [bbat_pkg::AXES];
   bbat_pkg::coef_type  coef     [bbat_pkg::AXES][bbat_pkg::AXES];
   bbat_pkg::prod_type  lo_prod_in [bbat_pkg::AXES][bbat_pkg::AXES];
   bbat_pkg::prod_type  hi_prod_in [bbat_pkg::AXES][bbat_pkg::AXES];
   bbat_pkg::prod_type  lo_prod_ff [bbat_pkg::AXES][bbat_pkg::AXES];
   bbat_pkg::prod_type  hi_prod_ff [bbat_pkg::AXES][bbat_pkg::AXES];
   logic                valid_ff;

   assign lo_coord[0] = req_word.in_min_x;
   assign lo_coord[1] = req_word.in_min_y;
   assign lo_coord[2] = req_word.in_min_z;
   assign hi_coord[0] = req_word.in_max_x;
   assign hi_coord[1] = req_word.in_max_y;
   assign hi_coord[2] = req_word.in_max_z;

   // Row a, column j holds the coefficient of input axis j for output axis a.
   always_comb begin
      for (int a = 0; a < bbat_pkg::AXES; a++) begin
         for (int j = 0; j < bbat_pkg::AXES; j++) begin
            coef[a][j]       = bbat_pkg::coef_type'(rows[a][j*bbat_pkg::COEF_W +: bbat_pkg::COEF_W]);
            lo_prod_in[a][j] = bbat_pkg::prod_type'(coef[a][j])
                             * bbat_pkg::prod_type'(lo_coord[j]);
            hi_prod_in[a][j] = bbat_pkg::prod_type'(coef[a][j])
                             * bbat_pkg::prod_type'(hi_coord[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && in_valid) begin
         lo_prod_ff <= lo_prod_in;
         hi_prod_ff <= hi_prod_in;
      end
   end

   assign out_valid = valid_ff;
   assign lo_prod   = lo_prod_ff;
   assign hi_prod   = hi_prod_ff;

endmodule

/* rtl/bbat_minmax_stage.sv */
// ----------------------------------------------------------------------------
// bbat_minmax_stage
// Second stage: keeps the smaller and the larger of each product pair.
// ----------------------------------------------------------------------------
module bbat_minmax_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               in_valid,
   input  bbat_pkg::prod_type lo_prod [bbat_pkg::AXES][bbat_pkg::AXES],
   input  bbat_pkg::prod_type hi_prod [bbat_pkg::AXES][bbat_pkg::AXES],
   output logic               out_valid,
   output bbat_pkg::prod_type min_prod [bbat_pkg::AXES][bbat_pkg::AXES],
   output bbat_pkg::prod_type max_prod [bbat_pkg::AXES][bbat_pkg::AXES]
);

   bbat_pkg::prod_type min_prod_in [bbat_pkg::AXES][bbat_pkg::AXES];
   bbat_pkg::prod_type max_prod_in [bbat_pkg::AXES][bbat_pkg::AXES];
   bbat_pkg::prod_type min_prod_ff [bbat_pkg::AXES][bbat_pkg::AXES];
   bbat_pkg::prod_type max_prod_ff [bbat_pkg::AXES][bbat_pkg::AXES];
   logic               valid_ff;

   // The ends are compared as products, so an inverted input box or a
   // negative coefficient needs no special handling.
   always_comb begin
      for (int a = 0; a < bbat_pkg::AXES; a++) begin
         for (int j = 0; j < bbat_pkg::AXES; j++) begin
            if (lo_prod[a][j] < hi_prod[a][j]) begin
               min_prod_in[a][j] = lo_prod[a][j];
               max_prod_in[a][j] = hi_prod[a][j];
            end else begin
               min_prod_in[a][j] = hi_prod[a][j];
               max_prod_in[a][j] = lo_prod[a][j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && in_valid) begin
         min_prod_ff <= min_prod_in;
         max_prod_ff <= max_prod_in;
      end
   end

   assign out_valid = valid_ff;
   assign min_prod  = min_prod_ff;
   assign max_prod  = max_prod_ff;

endmodule

/* rtl/bbat_sum_stage.sv */
// ----------------------------------------------------------------------------
// bbat_sum_stage
// Third stage: adds the selected products and the translation per axis.
// ----------------------------------------------------------------------------
module bbat_sum_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               in_valid,
   input  bbat_pkg::row_type  rows [bbat_pkg::AXES],
   input  bbat_pkg::prod_type min_prod [bbat_pkg::AXES][bbat_pkg::AXES],
   input  bbat_pkg::prod_type max_prod [bbat_pkg::AXES][bbat_pkg::AXES],
   output logic               out_valid,
   output bbat_pkg::acc_type  min_acc [bbat_pkg::AXES],
   output bbat_pkg::acc_type  max_acc [bbat_pkg::AXES]
);

   bbat_pkg::trans_type trans      [bbat_pkg::AXES];
   bbat_pkg::acc_type   trans_acc  [bbat_pkg::AXES];
   bbat_pkg::acc_type   min_acc_in [bbat_pkg::AXES];
   bbat_pkg::acc_type   max_acc_in [bbat_pkg::AXES];
   bbat_pkg::acc_type   min_acc_ff [bbat_pkg::AXES];
   bbat_pkg::acc_type   max_acc_ff [bbat_pkg::AXES];
   logic                valid_ff;

   // The translation is Q8.8; it is aligned to the 20 fraction bits of the
   // products before the add.
   always_comb begin
      for (int a = 0; a < bbat_pkg::AXES; a++) begin
         trans[a]     = bbat_pkg::trans_type'(rows[a][bbat_pkg::TRANS_LSB +: bbat_pkg::TRANS_W]);
         trans_acc[a] = bbat_pkg::acc_type'(trans[a]) <<< bbat_pkg::COEF_FRAC;
         min_acc_in[a] = bbat_pkg::acc_type'(min_prod[a][0])
                       + bbat_pkg::acc_type'(min_prod[a][1])
                       + bbat_pkg::acc_type'(min_prod[a][2])
                       + trans_acc[a];
         max_acc_in[a] = bbat_pkg::acc_type'(max_prod[a][0])
                       + bbat_pkg::acc_type'(max_prod[a][1])
                       + bbat_pkg::acc_type'(max_prod[a][2])
                       + trans_acc[a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && in_valid) begin
         min_acc_ff <= min_acc_in;
         max_acc_ff <= max_acc_in;
      end
   end

   assign out_valid = valid_ff;
   assign min_acc   = min_acc_ff;
   assign max_acc   = max_acc_ff;

endmodule

/* rtl/bbat_sat_stage.sv */
// ----------------------------------------------------------------------------
// bbat_sat_stage
// Last stage: floors to Q8.8, saturates and holds the result word.
// ----------------------------------------------------------------------------
module bbat_sat_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   in_valid,
   input  bbat_pkg::acc_type      min_acc [bbat_pkg::AXES],
   input  bbat_pkg::acc_type      max_acc [bbat_pkg::AXES],
   output logic                   out_valid,
   output bbat_pkg::rsp_word_type rsp_word
);

   bbat_pkg::sh_type       min_sh  [bbat_pkg::AXES];
   bbat_pkg::sh_type       max_sh  [bbat_pkg::AXES];
   bbat_pkg::coord_type    min_out [bbat_pkg::AXES];
   bbat_pkg::coord_type    max_out [bbat_pkg::AXES];
   logic [bbat_pkg::AXES-1:0] min_clip;
   logic [bbat_pkg::AXES-1:0] max_clip;
   bbat_pkg::rsp_word_type rsp_word_in;
   bbat_pkg::rsp_word_type rsp_word_ff;
   logic                   valid_ff;

   function automatic bbat_pkg::coord_type saturate(input bbat_pkg::sh_type v);
      bbat_pkg::coord_type r;
      if (v > bbat_pkg::SAT_HI) begin
         r = bbat_pkg::coord_type'(bbat_pkg::SAT_HI);
      end else if (v < bbat_pkg::SAT_LO) begin
         r = bbat_pkg::coord_type'(bbat_pkg::SAT_LO);
      end else begin
         r = bbat_pkg::coord_type'(v);
      end
      return r;
   endfunction

   // An arithmetic shift rounds toward minus infinity, as the format needs.
   always_comb begin
      for (int a = 0; a < bbat_pkg::AXES; a++) begin
         min_sh[a]   = bbat_pkg::sh_type'(min_acc[a] >>> bbat_pkg::COEF_FRAC);
         max_sh[a]   = bbat_pkg::sh_type'(max_acc[a] >>> bbat_pkg::COEF_FRAC);
         min_out[a]  = saturate(min_sh[a]);
         max_out[a]  = saturate(max_sh[a]);
         min_clip[a] = (min_sh[a] > bbat_pkg::SAT_HI) || (min_sh[a] < bbat_pkg::SAT_LO);
         max_clip[a] = (max_sh[a] > bbat_pkg::SAT_HI) || (max_sh[a] < bbat_pkg::SAT_LO);
      end
   end

   always_comb begin
      rsp_word_in.out_min_x = min_out[0];
      rsp_word_in.out_min_y = min_out[1];
      rsp_word_in.out_min_z = min_out[2];
      rsp_word_in.out_max_x = max_out[0];
      rsp_word_in.out_max_y = max_out[1];
      rsp_word_in.out_max_z = max_out[2];
      rsp_word_in.clipped   = |{min_clip, max_clip};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && in_valid) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign out_valid = valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

/* rtl/bounding_box_affine_transform.sv */
// ----------------------------------------------------------------------------
// bounding_box_affine_transform
// Transforms an axis-aligned box by a 3x4 affine matrix and returns the
// axis-aligned box that encloses the eight transformed corners.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid, req_stall, req_word) carries one box per
//   word as its minimum and maximum corners in signed Q8.8. The response
//   channel (rsp_valid, rsp_stall, rsp_word) returns the enclosing box in
//   signed Q8.8, saturated, with a clipped flag. A word moves at a clock edge
//   where valid is high and stall is low.
//   The csr channel writes one matrix row per word: index 0, 1 and 2 select
//   the x, y and z row, other indexes are dropped. csr_ready is always high.
//   Rows should only be written while no box is in flight.
// Pipeline and throughput:
//   Four register stages: multiply, pair select, sum, floor and saturate.
//   An accepted box passes the multiply, pair select and sum registers
//   before rsp_valid rises; one box enters every cycle unless stalled.
// Reset:
//   Synchronous reset empties the pipeline and loads the identity matrix.
// Stall:
//   Each stage holds its word while the next one is full and stalled; empty
//   stages keep filling, so req_stall rises only once all four stages hold a
//   word and rsp_stall is high.
// ----------------------------------------------------------------------------
module bounding_box_affine_transform (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  bbat_pkg::req_word_type      req_word,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output bbat_pkg::rsp_word_type      rsp_word,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  bbat_pkg::csr_index_type     csr_index,
   input  bbat_pkg::row_type           csr_wdata
);

   // Matrix rows as written through the csr channel.
   bbat_pkg::row_type row_x_ff;
   bbat_pkg::row_type row_y_ff;
   bbat_pkg::row_type row_z_ff;
   bbat_pkg::row_type rows [bbat_pkg::AXES];

   // Per-stage valid and advance.
   logic mul_valid;
   logic sel_valid;
   logic sum_valid;
   logic mul_en;
   logic sel_en;
   logic sum_en;
   logic sat_en;

   bbat_pkg::prod_type lo_prod  [bbat_pkg::AXES][bbat_pkg::AXES];
   bbat_pkg::prod_type hi_prod  [bbat_pkg::AXES][bbat_pkg::AXES];
   bbat_pkg::prod_type min_prod [bbat_pkg::AXES][bbat_pkg::AXES];
   bbat_pkg::prod_type max_prod [bbat_pkg::AXES][bbat_pkg::AXES];
   bbat_pkg::acc_type  min_acc  [bbat_pkg::AXES];
   bbat_pkg::acc_type  max_acc  [bbat_pkg::AXES];

   // The csr channel never pushes back.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_x_ff <= bbat_pkg::ROW_X_RESET;
         row_y_ff <= bbat_pkg::ROW_Y_RESET;
         row_z_ff <= bbat_pkg::ROW_Z_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bbat_pkg::CSR_ROW_X: row_x_ff <= csr_wdata;
            bbat_pkg::CSR_ROW_Y: row_y_ff <= csr_wdata;
            bbat_pkg::CSR_ROW_Z: row_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rows[0] = row_x_ff;
   assign rows[1] = row_y_ff;
   assign rows[2] = row_z_ff;

   // A stage may load when it is empty or when the stage after it moves on.
   // This collapses bubbles, so a waiting response does not hold back boxes
   // that still have room to advance.
   assign sat_en    = !rsp_valid || !rsp_stall;
   assign sum_en    = !sum_valid || sat_en;
   assign sel_en    = !sel_valid || sum_en;
   assign mul_en    = !mul_valid || sel_en;
   assign req_stall = !mul_en;

   bbat_mul_stage u_mul (
      .clock     (clock),
      .reset     (reset),
      .enable    (mul_en),
      .in_valid  (req_valid),
      .req_word  (req_word),
      .rows      (rows),
      .out_valid (mul_valid),
      .lo_prod   (lo_prod),
      .hi_prod   (hi_prod)
   );

   bbat_minmax_stage u_sel (
      .clock     (clock),
      .reset     (reset),
      .enable    (sel_en),
      .in_valid  (mul_valid),
      .lo_prod   (lo_prod),
      .hi_prod   (hi_prod),
      .out_valid (sel_valid),
      .min_prod  (min_prod),
      .max_prod  (max_prod)
   );

   bbat_sum_stage u_sum (
      .clock     (clock),
      .reset     (reset),
      .enable    (sum_en),
      .in_valid  (sel_valid),
      .rows      (rows),
      .min_prod  (min_prod),
      .max_prod  (max_prod),
      .out_valid (sum_valid),
      .min_acc   (min_acc),
      .max_acc   (max_acc)
   );

   bbat_sat_stage u_sat (
      .clock     (clock),
      .reset     (reset),
      .enable    (sat_en),
      .in_valid  (sum_valid),
      .min_acc   (min_acc),
      .max_acc   (max_acc),
      .out_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   // Back pressure reaches the request side only when every stage is full.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (mul_valid && sel_valid && sum_valid && rsp_valid))
      else $error("request stalled while the pipeline has an empty stage");

   // An accepted box always lands in the first stage.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> mul_valid)
      else $error("accepted box was not captured by the multiply stage");

   // Per-term selection makes each minimum bound no larger than its maximum,
   // even for an inverted input box; saturation keeps that order.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_word.out_min_x <= rsp_word.out_max_x) &&
                     (rsp_word.out_min_y <= rsp_word.out_max_y) &&
                     (rsp_word.out_min_z <= rsp_word.out_max_z)))
      else $error("transformed box has a minimum above its maximum");

endmodule

/* test/bounding_box_affine_transform_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounding_box_affine_transform_test
// Self-checking bench for the box transform. A short table of hand-picked
// boxes and matrix rows runs first. Eight phases of random boxes follow, each
// under its own matrix. Each response word is compared field by field
// against the oldest prediction: the hand-written response of the box's
// table row or, for the rest, a behavioral model of the transform. Both
// channels idle and stall in random bursts, except in the final phase.
// ----------------------------------------------------------------------------
module bounding_box_affine_transform_test;

   // The two-bit index space has one slot that maps to no row. Writes to it
   // must be dropped by the block.
   localparam bbat_pkg::csr_index_type CSR_UNUSED = bbat_pkg::csr_index_type'(3);

   localparam int PLAN_LEN   = 23;
   localparam int PHASES     = 8;
   localparam int PHASE_BOXES = 105;
   localparam int IDLE_LIMIT = 2000;
   localparam int REPORT_MAX = 10;

   typedef enum logic {STEP_BOX, STEP_CSR} step_kind_type;

   // One row of the directed table. A box row may carry a hand-written
   // expected response. When it does not, the behavioral model predicts it.
   typedef struct packed {
      step_kind_type           kind;
      bbat_pkg::csr_index_type index;
      bbat_pkg::row_type       data;
      bbat_pkg::req_word_type  box;
      bit                      typed;
      bbat_pkg::rsp_word_type  want;
   } plan_step_type;

   localparam plan_step_type DIRECTED_PLAN [PLAN_LEN] = '{
      // Identity matrix straight out of reset: every box comes back unchanged.
      '{STEP_BOX, bbat_pkg::CSR_ROW_X, '0,
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
      '{STEP_BOX, bbat_pkg::CSR_ROW_X, '0,
        '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b1,
        '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0}},
      '{STEP_BOX, bbat_pkg::CSR_ROW_X, '0,
        '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b1,
        '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0}},
      '{STEP_BOX, bbat_pkg::CSR_ROW_X, '0,
        '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000}, 1'b1,
        '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0}},
      // Inverted box: the corners are still built from the given values, so
      // the response is the box with each axis put in order.
      '{STEP_BOX, bbat_pkg::CSR_ROW_X, '0,
        '{16'h0100, 16'h0200, 16'hFD00, 16'hFF00, 16'hFE00, 16'h0300}, 1'b1,
        '{16'hFF00, 16'hFE00, 16'hFD00, 16'h0100, 16'h0200, 16'h0300, 1'b0}},
      '{STEP_BOX, bbat_pkg::CSR_ROW_X, '0,
        '{16'hAAAA, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555, 16'h5555}, 1'b1,
        '{16'hAAAA, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555, 16'h5555, 1'b0}},
      // A write to the unused index must leave the identity in place.
      '{STEP_CSR, CSR_UNUSED, 64'h1234_5678_9ABC_DEF0, '0, 1'b0, '0},
      '{STEP_BOX, bbat_pkg::CSR_ROW_X, '0,
        '{16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'h0500, 16'h0600}, 1'b1,
        '{16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'h0500, 16'h0600, 1'b0}},
      // Doubling x saturates a full-range box on both sides.
      '{STEP_CSR, bbat_pkg::CSR_ROW_X, 64'h0000_0000_0000_2000, '0, 1'b0, '0},
      '{STEP_BOX, bbat_pkg::CSR_ROW_X, '0,
        '{16'h8000, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000}, 1'b1,
        '{16'h8000, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 1'b1}},
      '{STEP_BOX, bbat_pkg::CSR_ROW_X, '0,
        '{16'h0100, 16'h0300, 16'h0000, 16'h0200, 16'h0400, 16'h0000}, 1'b1,
        '{16'h0200, 16'h0300, 16'h0000, 16'h0400, 16'h0400, 16'h0000, 1'b0}},
      // Largest translation on y.
      '{STEP_CSR, bbat_pkg::CSR_ROW_Y, 64'h7FFF_0000_1000_0000, '0, 1'b0, '0},
      '{STEP_BOX, bbat_pkg::CSR_ROW_X, '0,
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000}, 1'b0, '0},
      '{STEP_BOX, bbat_pkg::CSR_ROW_X, '0,
        '{16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
      // Half scale on y: odd negative values must round toward minus infinity.
      '{STEP_CSR, bbat_pkg::CSR_ROW_Y, 64'h0000_0000_0800_0000, '0, 1'b0, '0},
      '{STEP_BOX, bbat_pkg::CSR_ROW_X, '0,
        '{16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0001, 16'h0000}, 1'b0, '0},
      // Most negative coefficients and translation on z.
      '{STEP_CSR, bbat_pkg::CSR_ROW_Z, 64'h8000_8000_8000_8000, '0, 1'b0, '0},
      '{STEP_BOX, bbat_pkg::CSR_ROW_X, '0,
        '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0, '0},
      '{STEP_BOX, bbat_pkg::CSR_ROW_X, '0,
        '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000}, 1'b0, '0},
      '{STEP_CSR, bbat_pkg::CSR_ROW_X, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, '0},
      '{STEP_BOX, bbat_pkg::CSR_ROW_X, '0,
        '{16'h1234, 16'hEDCB, 16'h0F0F, 16'h4321, 16'h7000, 16'hF0F0}, 1'b0, '0},
      '{STEP_CSR, bbat_pkg::CSR_ROW_X, 64'h7FFF_7FFF_7FFF_7FFF, '0, 1'b0, '0},
      '{STEP_BOX, bbat_pkg::CSR_ROW_X, '0,
        '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0, '0}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   bbat_pkg::req_word_type  req_word = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   bbat_pkg::rsp_word_type  rsp_word;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   bbat_pkg::csr_index_type csr_index = bbat_pkg::CSR_ROW_X;
   bbat_pkg::row_type       csr_wdata = '0;

   // Bench-side tags that travel with each request word. They tell the
   // monitor whether the table already holds the expected response.
   logic                    req_typed = 1'b0;
   bbat_pkg::rsp_word_type  req_typed_word = '0;

   // The bench's own copy of the three matrix rows, indexed by axis.
   bbat_pkg::row_type       matrix_rows [3] =
      '{bbat_pkg::ROW_X_RESET, bbat_pkg::ROW_Y_RESET, bbat_pkg::ROW_Z_RESET};

   bbat_pkg::rsp_word_type  pending_boxes [$];
   int            boxes_issued = 0;
   int            boxes_returned = 0;
   int            mismatches = 0;
   int            idle_cycles = 0;

   // Idling controls, set per phase by the stimulus process.
   bit            quiet = 1'b0;
   int            gap_odds = 0;
   int            stall_odds = 0;
   int            stall_left = 0;

   bounding_box_affine_transform uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Behavioral transform. Each of the eight corners goes through the three
   // rows with exact 64-bit sums. An arithmetic shift by the coefficient
   // fraction floors the result to Q8.8. The per-axis extremes are saturated
   // only at the very end.
   function automatic bbat_pkg::rsp_word_type transform_box(bbat_pkg::req_word_type box);
      longint lo [3];
      longint hi [3];
      longint corner [3];
      longint coef [3];
      longint extreme [6];
      longint trans;
      longint acc;
      longint limit_hi;
      longint limit_lo;
      bbat_pkg::coord_type clamped [6];
      bit clip;
      bbat_pkg::rsp_word_type r;
      clip = 1'b0;
      lo[0] = longint'(box.in_min_x);
      lo[1] = longint'(box.in_min_y);
      lo[2] = longint'(box.in_min_z);
      hi[0] = longint'(box.in_max_x);
      hi[1] = longint'(box.in_max_y);
      hi[2] = longint'(box.in_max_z);
      for (int c = 0; c < 8; c++) begin
         corner[0] = c[2] ? hi[0] : lo[0];
         corner[1] = c[1] ? hi[1] : lo[1];
         corner[2] = c[0] ? hi[2] : lo[2];
         for (int a = 0; a < 3; a++) begin
            coef[0] = longint'(bbat_pkg::coef_type'(matrix_rows[a][15:0]));
            coef[1] = longint'(bbat_pkg::coef_type'(matrix_rows[a][31:16]));
            coef[2] = longint'(bbat_pkg::coef_type'(matrix_rows[a][47:32]));
            trans   = longint'(bbat_pkg::trans_type'(matrix_rows[a][63:48]));
            acc = coef[0] * corner[0] + coef[1] * corner[1] + coef[2] * corner[2]
                  + (trans <<< bbat_pkg::COEF_FRAC);
            acc = acc >>> bbat_pkg::COEF_FRAC;
            if (c == 0 || acc < extreme[a])
               extreme[a] = acc;
            if (c == 0 || acc > extreme[a + 3])
               extreme[a + 3] = acc;
         end
      end
      limit_hi = (longint'(1) <<< (bbat_pkg::COORD_WIDTH - 1)) - 1;
      limit_lo = -limit_hi - 1;
      for (int k = 0; k < 6; k++) begin
         if (extreme[k] > limit_hi) begin
            extreme[k] = limit_hi;
            clip = 1'b1;
         end else if (extreme[k] < limit_lo) begin
            extreme[k] = limit_lo;
            clip = 1'b1;
         end
         clamped[k] = bbat_pkg::coord_type'(extreme[k]);
      end
      r.out_min_x = clamped[0];
      r.out_min_y = clamped[1];
      r.out_min_z = clamped[2];
      r.out_max_x = clamped[3];
      r.out_max_y = clamped[4];
      r.out_max_z = clamped[5];
      r.clipped   = clip;
      return r;
   endfunction

   // A random matrix row. Each 16-bit slot is full-range noise, a modest
   // value around zero, zero, or one of the two signed extremes.
   function automatic bbat_pkg::row_type random_row();
      bbat_pkg::row_type r;
      for (int k = 0; k < 4; k++) begin
         case ($urandom_range(0, 7))
            0, 1:    r[k*16 +: 16] = 16'($urandom);
            2, 3, 4: r[k*16 +: 16] = 16'(int'($urandom_range(0, 16'h2000)) - 16'h1000);
            5:       r[k*16 +: 16] = 16'h0000;
            6:       r[k*16 +: 16] = 16'h7FFF;
            default: r[k*16 +: 16] = 16'h8000;
         endcase
      end
      return r;
   endfunction

   // A random box. Most axes are well-formed with small or full-range
   // extents. A share of the axes are inverted, degenerate or full scale.
   function automatic bbat_pkg::req_word_type random_box();
      bbat_pkg::coord_type lo [3];
      bbat_pkg::coord_type hi [3];
      bbat_pkg::coord_type swap;
      bbat_pkg::req_word_type b;
      for (int a = 0; a < 3; a++) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               lo[a] = bbat_pkg::coord_type'($urandom);
               hi[a] = bbat_pkg::coord_type'($urandom);
            end
            2, 3, 4, 5: begin
               lo[a] = bbat_pkg::coord_type'(int'($urandom_range(0, 4096)) - 2048);
               hi[a] = bbat_pkg::coord_type'(int'(lo[a]) + int'($urandom_range(0, 2048)));
            end
            6, 7: begin
               lo[a] = bbat_pkg::coord_type'($urandom);
               hi[a] = bbat_pkg::coord_type'($urandom);
               if (lo[a] > hi[a]) begin
                  swap  = lo[a];
                  lo[a] = hi[a];
                  hi[a] = swap;
               end
            end
            8: begin
               lo[a] = bbat_pkg::coord_type'(16'h8000);
               hi[a] = bbat_pkg::coord_type'(16'h7FFF);
            end
            default: begin
               lo[a] = bbat_pkg::coord_type'($urandom);
               hi[a] = lo[a];
            end
         endcase
      end
      b.in_min_x = lo[0];
      b.in_min_y = lo[1];
      b.in_min_z = lo[2];
      b.in_max_x = hi[0];
      b.in_max_y = hi[1];
      b.in_max_z = hi[2];
      return b;
   endfunction

   // Offers one box and returns at the edge that takes it. When idling is
   // on, the offer may be preceded by a burst of cycles with valid low.
   task automatic send_box(bbat_pkg::req_word_type box, bit typed,
                           bbat_pkg::rsp_word_type want);
      int gap;
      csr_valid <= 1'b0;
      if (!quiet && $urandom_range(0, 99) < gap_odds) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_word       <= box;
      req_typed      <= typed;
      req_typed_word <= want;
      do @(posedge clock); while (req_stall);
      boxes_issued++;
   endtask

   // Stops offering boxes and waits until every issued box has come back.
   // Matrix writes happen only after this.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (boxes_returned != boxes_issued);
   endtask

   // Writes one row and mirrors it into the bench's copy. The unused index
   // changes nothing. csr_valid stays high so that writes can run back to
   // back; the next box offer lowers it.
   task automatic write_row(bbat_pkg::csr_index_type index, bbat_pkg::row_type value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         bbat_pkg::CSR_ROW_X: matrix_rows[0] = value;
         bbat_pkg::CSR_ROW_Y: matrix_rows[1] = value;
         bbat_pkg::CSR_ROW_Z: matrix_rows[2] = value;
         default: ;
      endcase
   endtask

   task automatic check_field(string name, bbat_pkg::coord_type want,
                              bbat_pkg::coord_type got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= REPORT_MAX)
            $display("box %0d: %s expected %0d, got %0d",
                     boxes_returned, name, want, got);
      end
   endtask

   // The response side stalls in random bursts. The odds of a burst being
   // a stall rather than a run are set per phase.
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
      end else begin
         stall_left = $urandom_range(1, 14) - 1;
         rsp_stall <= ($urandom_range(0, 99) < stall_odds);
      end
   end

   // Monitor. Both channels are sampled at the same edge in one process:
   // the prediction for a box taken at an edge is queued before any response
   // of that edge is checked. The watchdog counts edges at which no word
   // moves on any channel.
   always @(posedge clock) begin
      bbat_pkg::rsp_word_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            pending_boxes.push_back(req_typed ? req_typed_word : transform_box(req_word));
         if (rsp_valid && !rsp_stall) begin
            if (pending_boxes.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("box %0d: response word with nothing expected, got %h",
                           boxes_returned, rsp_word);
            end else begin
               want = pending_boxes.pop_front();
               check_field("out_min_x", want.out_min_x, rsp_word.out_min_x);
               check_field("out_min_y", want.out_min_y, rsp_word.out_min_y);
               check_field("out_min_z", want.out_min_z, rsp_word.out_min_z);
               check_field("out_max_x", want.out_max_x, rsp_word.out_max_x);
               check_field("out_max_y", want.out_max_y, rsp_word.out_max_y);
               check_field("out_max_z", want.out_max_z, rsp_word.out_max_z);
               check_field("clipped", bbat_pkg::coord_type'(want.clipped),
                           bbat_pkg::coord_type'(rsp_word.clipped));
            end
            boxes_returned++;
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("bounding_box_affine_transform_test: done, errors");
            $finish;
         end
      end
   end

   initial begin : stimulus
      plan_step_type step;
      bbat_pkg::row_type chosen;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed table. Rows are written only once the pipeline is empty.
      for (int i = 0; i < PLAN_LEN; i++) begin
         step = DIRECTED_PLAN[i];
         if (step.kind == STEP_CSR) begin
            wait_for_results();
            write_row(step.index, step.data);
         end else begin
            send_box(step.box, step.typed, step.want);
         end
      end

      // Random phases. The first four load the identity, a row of all ones
      // and the two uniform signed extremes of the row encoding; the rest
      // load random rows. The final phase runs with no idling at all.
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_for_results();
         quiet      = (phase == PHASES - 1);
         gap_odds   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
         stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
         for (int r = 0; r < 3; r++) begin
            case (phase)
               0: chosen = (r == 0) ? bbat_pkg::ROW_X_RESET :
                           (r == 1) ? bbat_pkg::ROW_Y_RESET : bbat_pkg::ROW_Z_RESET;
               1: chosen = 64'hFFFF_FFFF_FFFF_FFFF;
               2: chosen = 64'h7FFF_7FFF_7FFF_7FFF;
               3: chosen = 64'h8000_8000_8000_8000;
               default: chosen = random_row();
            endcase
            write_row(bbat_pkg::csr_index_type'(r), chosen);
         end
         if ($urandom_range(0, 1) == 1)
            write_row(CSR_UNUSED, {$urandom, $urandom});
         for (int n = 0; n < PHASE_BOXES; n++) begin
            // Once in the run the sender holds off until the pipeline has
            // emptied completely, then picks up again.
            if (phase == 2 && n == PHASE_BOXES / 2)
               wait_for_results();
            send_box(random_box(), 1'b0, '0);
         end
      end

      wait_for_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_boxes.size() == 0) begin
         $display("bounding_box_affine_transform_test: done, clean");
      end else begin
         if (pending_boxes.size() != 0)
            $display("%0d expected response words never arrived", pending_boxes.size());
         $display("bounding_box_affine_transform_test: done, errors");
      end
      $finish;
   end

endmodule
